// ----- rtl/rzc_pkg.sv -----
package rzc_pkg;

    localparam int TABLE_ROWS_DEF = 4096;

    // stream and config widths
    localparam int S_DATA_W   = 184;
    localparam int S_USER_W   = 3;
    localparam int M_DATA_W   = 40;
    localparam int M_USER_W   = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    // field positions in s_tdata, also the row layout in the table
    localparam int CHROM_LSB = 0;
    localparam int START_LSB = 16;
    localparam int END_LSB   = 48;
    localparam int COV_LSB   = 80;
    localparam int NEG_LSB   = 96;
    localparam int POS_LSB   = 112;
    localparam int SUM_LSB   = 128;
    localparam int GOOD_LSB  = 168;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [2:0] SIG_NONE    = 3'd0;
    localparam logic [2:0] SIG_LOWCOV  = 3'd1;
    localparam logic [2:0] SIG_MIS     = 3'd2;
    localparam logic [2:0] SIG_NEUTRAL = 3'd3;
    localparam logic [2:0] SIG_NEG     = 3'd4;
    localparam logic [2:0] SIG_POS     = 3'd5;

    localparam logic [2:0] REG_MEAN    = 3'd0;
    localparam logic [2:0] REG_SD      = 3'd1;
    localparam logic [2:0] REG_THRESH  = 3'd2;
    localparam logic [2:0] REG_MINCOV  = 3'd3;
    localparam logic [2:0] REG_MINMIS  = 3'd4;
    localparam logic [2:0] REG_MINSUP  = 3'd5;

    localparam int SQRT_STEPS = 16;
    localparam int DIV_STEPS  = 23;

    typedef struct packed {
        logic capture;
        logic do_clear;
        logic do_load;
        logic srch_init;
        logic srch_rd;
        logic srch_cmp;
        logic fetch_rd;
        logic fetch_chk;
        logic z_init;
        logic sqrt_step;
        logic mag_calc;
        logic prod_calc;
        logic psum_calc;
        logic div_init;
        logic div_step;
        logic out_load;
    } rzc_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       srch_open;
        logic       lo_zero;
        logic       row_match;
        logic       out_busy;
    } rzc_stat_t;

endpackage

// ----- rtl/rzc_ctrl.sv -----
module rzc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  rzc_pkg::rzc_stat_t stat,
    output rzc_pkg::rzc_cmd_t  cmd
);
    import rzc_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_SCHK   = 4'd2;
    localparam logic [3:0] ST_SCMP   = 4'd3;
    localparam logic [3:0] ST_FCHK   = 4'd4;
    localparam logic [3:0] ST_ZINIT  = 4'd5;
    localparam logic [3:0] ST_SQRT   = 4'd6;
    localparam logic [3:0] ST_MAG    = 4'd7;
    localparam logic [3:0] ST_PROD   = 4'd8;
    localparam logic [3:0] ST_PSUM   = 4'd9;
    localparam logic [3:0] ST_DIVI   = 4'd10;
    localparam logic [3:0] ST_DIV    = 4'd11;
    localparam logic [3:0] ST_FIN    = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [4:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_IDLE;
                case (stat.op)
                    OP_CLEAR: cmd.do_clear = 1'b1;
                    OP_LOAD:  cmd.do_load  = 1'b1;
                    OP_QUERY: begin
                        cmd.srch_init = 1'b1;
                        state_next    = ST_SCHK;
                    end
                    default: ;
                endcase
            end
            ST_SCHK: begin
                if (stat.srch_open) begin
                    cmd.srch_rd = 1'b1;
                    state_next  = ST_SCMP;
                end else if (stat.lo_zero) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.fetch_rd = 1'b1;
                    state_next   = ST_FCHK;
                end
            end
            ST_SCMP: begin
                cmd.srch_cmp = 1'b1;
                state_next   = ST_SCHK;
            end
            ST_FCHK: begin
                cmd.fetch_chk = 1'b1;
                state_next    = stat.row_match ? ST_ZINIT : ST_FIN;
            end
            ST_ZINIT: begin
                cmd.z_init = 1'b1;
                step_next  = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (step_reg == 5'(SQRT_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = ST_MAG;
                end else begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_MAG: begin
                cmd.mag_calc = 1'b1;
                state_next   = ST_PROD;
            end
            ST_PROD: begin
                cmd.prod_calc = 1'b1;
                state_next    = ST_PSUM;
            end
            ST_PSUM: begin
                cmd.psum_calc = 1'b1;
                state_next    = ST_DIVI;
            end
            ST_DIVI: begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (step_reg == 5'(DIV_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = ST_FIN;
                end else begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_FIN: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- rtl/rzc_dp.sv -----
module rzc_dp #(
    parameter int TABLE_ROWS = rzc_pkg::TABLE_ROWS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [rzc_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic [rzc_pkg::S_USER_W-1:0]    s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rzc_pkg::M_DATA_W-1:0]    m_tdata,
    output logic [rzc_pkg::M_USER_W-1:0]    m_tuser,
    input  logic                            cfg_we,
    input  logic [rzc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [rzc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  rzc_pkg::rzc_cmd_t               cmd,
    output rzc_pkg::rzc_stat_t              stat
);
    import rzc_pkg::*;

    localparam int AW = $clog2(TABLE_ROWS);
    localparam int CW = AW + 1;

    logic [23:0] mean_reg, sd_reg;
    logic [15:0] thresh_reg, mincov_reg, minmis_reg, minsup_reg;

    logic [S_DATA_W-1:0] mem [TABLE_ROWS];
    logic [S_DATA_W-1:0] rd_reg;
    logic [S_DATA_W-1:0] in_reg;
    logic [1:0]          op_reg;
    logic                mode_reg;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       lo_reg, hi_reg;
    logic [AW-1:0]       idx_reg;
    logic                found_reg;

    logic [39:0] b_reg, den_reg;
    logic [15:0] root_reg;
    logic [18:0] srem_reg;
    logic [31:0] sv_reg;
    logic [47:0] mag_reg;
    logic        neg_reg;
    logic [39:0] plo_reg, phi_reg;
    logic [63:0] p_reg;
    logic        sat_reg;
    logic [39:0] drem_reg;
    logic [22:0] dlow_reg;
    logic [22:0] quot_reg;

    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [M_USER_W-1:0] m_user_reg;

    // row fields
    logic [15:0] q_chrom, r_chrom, r_cov, r_neg, r_pos, r_good;
    logic [31:0] q_pos, r_start, r_end;
    logic [39:0] r_sum;

    assign q_chrom = in_reg[CHROM_LSB +: 16];
    assign q_pos   = in_reg[START_LSB +: 32];
    assign r_chrom = rd_reg[CHROM_LSB +: 16];
    assign r_start = rd_reg[START_LSB +: 32];
    assign r_end   = rd_reg[END_LSB +: 32];
    assign r_cov   = rd_reg[COV_LSB +: 16];
    assign r_neg   = rd_reg[NEG_LSB +: 16];
    assign r_pos   = rd_reg[POS_LSB +: 16];
    assign r_sum   = rd_reg[SUM_LSB +: 40];
    assign r_good  = rd_reg[GOOD_LSB +: 16];

    logic [CW-1:0] mid, lo_m1;
    logic [AW-1:0] rd_addr;
    logic          key_le;

    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_m1   = lo_reg - CW'(1);
    assign rd_addr = cmd.srch_rd ? mid[AW-1:0] : lo_m1[AW-1:0];
    assign key_le  = {r_chrom, r_start} <= {q_chrom, q_pos};

    assign stat.op        = op_reg;
    assign stat.srch_open = lo_reg < hi_reg;
    assign stat.lo_zero   = (lo_reg == '0);
    assign stat.row_match = (r_chrom == q_chrom) && (q_pos <= r_end);
    assign stat.out_busy  = m_valid_reg && !m_tready;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_reg   <= 24'd0;
            sd_reg     <= 24'd256;
            thresh_reg <= 16'd768;
            mincov_reg <= 16'd5;
            minmis_reg <= 16'd5;
            minsup_reg <= 16'd5;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MEAN:   mean_reg   <= cfg_wdata;
                REG_SD:     sd_reg     <= cfg_wdata;
                REG_THRESH: thresh_reg <= cfg_wdata[15:0];
                REG_MINCOV: mincov_reg <= cfg_wdata[15:0];
                REG_MINMIS: minmis_reg <= cfg_wdata[15:0];
                REG_MINSUP: minsup_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // row table
    always_ff @(posedge aclk) begin
        if (cmd.do_load && (cnt_reg != CW'(TABLE_ROWS))) begin
            mem[cnt_reg[AW-1:0]] <= in_reg;
        end
        if (cmd.srch_rd || cmd.fetch_rd) begin
            rd_reg <= mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            found_reg <= 1'b0;
        end else begin
            if (cmd.do_clear) begin
                cnt_reg <= '0;
            end else if (cmd.do_load && (cnt_reg != CW'(TABLE_ROWS))) begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.srch_init) begin
                found_reg <= 1'b0;
            end else if (cmd.fetch_chk) begin
                found_reg <= stat.row_match;
            end
        end
    end

    logic [23:0] sd_eff;
    logic [18:0] srem_t, trial;
    logic [47:0] a_val;
    logic [40:0] dt;

    assign sd_eff = (sd_reg == '0) ? 24'd1 : sd_reg;
    assign srem_t = {srem_reg[16:0], sv_reg[31:30]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign a_val  = {r_sum, 8'd0};
    assign dt     = {drem_reg, dlow_reg[22]};

    // query datapath
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg   <= s_tdata;
            op_reg   <= s_tuser[1:0];
            mode_reg <= s_tuser[2];
        end
        if (cmd.srch_init) begin
            lo_reg <= '0;
            hi_reg <= cnt_reg;
        end
        if (cmd.srch_cmp) begin
            if (key_le) lo_reg <= mid + CW'(1);
            else        hi_reg <= mid;
        end
        if (cmd.fetch_rd) begin
            idx_reg <= lo_m1[AW-1:0];
        end
        if (cmd.z_init) begin
            b_reg    <= mean_reg * r_cov;
            den_reg  <= sd_eff * r_cov;
            sv_reg   <= {r_cov, 16'd0};
            root_reg <= '0;
            srem_reg <= '0;
        end
        // one result bit per step
        if (cmd.sqrt_step) begin
            sv_reg <= {sv_reg[29:0], 2'b00};
            if (srem_t >= trial) begin
                srem_reg <= srem_t - trial;
                root_reg <= {root_reg[14:0], 1'b1};
            end else begin
                srem_reg <= srem_t;
                root_reg <= {root_reg[14:0], 1'b0};
            end
        end
        if (cmd.mag_calc) begin
            neg_reg <= {8'd0, b_reg} > a_val;
            mag_reg <= ({8'd0, b_reg} > a_val) ? ({8'd0, b_reg} - a_val)
                                               : (a_val - {8'd0, b_reg});
        end
        if (cmd.prod_calc) begin
            plo_reg <= mag_reg[23:0] * root_reg;
            phi_reg <= mag_reg[47:24] * root_reg;
        end
        if (cmd.psum_calc) begin
            p_reg <= {phi_reg, 24'd0} + {24'd0, plo_reg};
        end
        // quotient at or above 2^23 saturates, else 23 bits remain
        if (cmd.div_init) begin
            sat_reg  <= p_reg[63:23] >= {1'b0, den_reg};
            drem_reg <= p_reg[62:23];
            dlow_reg <= p_reg[22:0];
            quot_reg <= '0;
        end
        if (cmd.div_step) begin
            dlow_reg <= {dlow_reg[21:0], 1'b0};
            if (dt >= {1'b0, den_reg}) begin
                drem_reg <= 40'(dt - {1'b0, den_reg});
                quot_reg <= {quot_reg[21:0], 1'b1};
            end else begin
                drem_reg <= dt[39:0];
                quot_reg <= {quot_reg[21:0], 1'b0};
            end
        end
    end

    // z-score and classification
    logic signed [23:0] z_val;
    logic signed [24:0] z_ext, t_ext;
    logic signed [16:0] bad;
    logic               mis, ge_t, le_nt;
    logic [2:0]         sig_pos, sig_neg, sig_cls;

    always_comb begin
        if (r_cov == '0)  z_val = '0;
        else if (neg_reg) z_val = sat_reg ? 24'sh800000 : -$signed({1'b0, quot_reg});
        else              z_val = sat_reg ? 24'sh7FFFFF : $signed({1'b0, quot_reg});
        z_ext   = 25'(z_val);
        t_ext   = $signed({9'd0, thresh_reg});
        ge_t    = z_ext >= t_ext;
        le_nt   = z_ext <= -t_ext;
        bad     = $signed({1'b0, r_cov}) - $signed({1'b0, r_good});
        mis     = bad >= $signed({1'b0, minmis_reg});
        sig_neg = (r_neg >= minsup_reg) ? SIG_NEG : SIG_NEUTRAL;
        sig_pos = (r_pos >= minsup_reg) ? SIG_POS : SIG_NEUTRAL;
        if (r_cov < mincov_reg) begin
            sig_cls = SIG_LOWCOV;
        end else if (!mode_reg) begin
            if (mis)                 sig_cls = SIG_MIS;
            else if (!ge_t && !le_nt) sig_cls = SIG_NEUTRAL;
            else if (le_nt)          sig_cls = sig_neg;
            else                     sig_cls = sig_pos;
        end else begin
            if (le_nt)     sig_cls = sig_neg;
            else if (ge_t) sig_cls = sig_pos;
            else if (mis)  sig_cls = SIG_MIS;
            else           sig_cls = SIG_NEUTRAL;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            if (found_reg) begin
                m_user_reg <= sig_cls;
                m_data_reg <= {4'd0, z_val, 12'(idx_reg)};
            end else begin
                m_user_reg <= SIG_NONE;
                m_data_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- rtl/range_zstat_signal_classifier.sv -----
// Genomic range table with z-score classification. A load (s_tuser operation 1) appends
// one row; rows must arrive in ascending (chrom, start) order and loads past TABLE_ROWS
// are dropped; operation 0 empties the table; operation 2 queries a position and returns
// one result: signal in m_tuser, row index and 8-fractional-bit z-score in m_tdata.
// A query is accepted and decoded, then runs a binary search with one table read per
// probe (up to ceil(log2(rows+1)) probes), fetches and checks the row, sets up and takes
// the square root, forms the product, runs the restoring divide and loads the output.
// A query that finds no row ends after the search, or after the row check when a row
// was fetched. A result that waits on m_tready stalls only the next query before its
// output load, while loads and clears go on. Only one item is processed at a time.
module range_zstat_signal_classifier #(
    parameter int TABLE_ROWS = rzc_pkg::TABLE_ROWS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // chrom_id, position, range_end_pos, coverage, neg_count, pos_count,
    // size_total, good_orient
    input  logic [rzc_pkg::S_DATA_W-1:0]    s_tdata,
    // operation, mode
    input  logic [rzc_pkg::S_USER_W-1:0]    s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // row_index, z_score, zero pad
    output logic [rzc_pkg::M_DATA_W-1:0]    m_tdata,
    // signal
    output logic [rzc_pkg::M_USER_W-1:0]    m_tuser,
    input  logic                            cfg_we,
    input  logic [rzc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [rzc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import rzc_pkg::*;

    rzc_cmd_t  cmd;
    rzc_stat_t stat;

    rzc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rzc_dp #(
        .TABLE_ROWS (TABLE_ROWS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
